/* src/edid_bbp_pkg.sv */
// ----------------------------------------------------------------------------
// edid_bbp_pkg
// Shared constants, types and helpers of the EDID base block parser.
// ----------------------------------------------------------------------------
package edid_bbp_pkg;

    localparam int unsigned BlockLen  = 128;
    localparam int unsigned DescFirst = 54;
    localparam int unsigned DescLen   = 18;
    localparam int unsigned DescCount = 4;
    localparam int unsigned DescEnd   = DescFirst + DescCount * DescLen;
    localparam int unsigned NameLen   = 13;
    localparam int unsigned NameOff   = 5;

    localparam logic [7:0] HdrZero  = 8'h00;
    localparam logic [7:0] HdrFf    = 8'hFF;
    localparam logic [7:0] NameTag  = 8'hFC;

    localparam logic [7:0] ChNul = 8'h00;
    localparam logic [7:0] ChTab = 8'h09;
    localparam logic [7:0] ChLf  = 8'h0A;
    localparam logic [7:0] ChVt  = 8'h0B;
    localparam logic [7:0] ChFf  = 8'h0C;
    localparam logic [7:0] ChCr  = 8'h0D;
    localparam logic [7:0] ChSp  = 8'h20;

    localparam int unsigned OutDataW = 136;

    // "Unknown", character 0 in the low byte
    localparam logic [63:0] UnknownChars = 64'h006E_776F_6E6B_6E55;
    localparam logic [3:0]  UnknownLen   = 4'd7;

    typedef logic [NameLen-1:0][7:0] name_bytes_t;

    // block summary handed from the capture stage to the name shaper
    typedef struct packed {
        logic        found;
        logic        blk_ok;
        logic [11:0] width;
        logic [11:0] height;
        name_bytes_t name;
    } snap_t;

    typedef struct packed {
        logic [39:0] name_chars_high;
        logic [63:0] name_chars_low;
        logic [3:0]  name_length;
        logic        name_found;
        logic [11:0] px_height;
        logic [11:0] px_width;
        logic        valid_res;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == ChSp) || (c == ChTab) || (c == ChVt) || (c == ChFf) ||
                   (c == ChLf) || (c == ChCr);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        is_term = (c == ChNul) || (c == ChCr) || (c == ChLf);
    endfunction

endpackage

/* src/edid_bbp_capture.sv */
// ----------------------------------------------------------------------------
// edid_bbp_capture
// Per-byte block state: header check, descriptor scan, name and size capture.
// ----------------------------------------------------------------------------
module edid_bbp_capture
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          beat_byte,
    input  logic                beat_last,
    output edid_bbp_pkg::snap_t snap
);

    logic [7:0] idx_reg, idx_next;
    logic       hdr_reg, hdr_next;
    logic       found_reg, found_next;
    logic [1:0] pz_reg, pz_next;
    logic [4:0] off_reg, off_next;
    logic [1:0] dnum_reg, dnum_next;
    logic [1:0] ndesc_reg, ndesc_next;
    logic [7:0] wl_reg, wl_next;
    logic [3:0] wh_reg, wh_next;
    logic [7:0] hl_reg, hl_next;
    logic [3:0] hh_reg, hh_next;

    edid_bbp_pkg::name_bytes_t store_reg, store_next;
    logic       wr_en;
    logic [3:0] wr_idx;
    logic       in_desc;
    logic       blk_ok;
    logic [4:0] off_rel;

    always_comb
    begin
        idx_next   = idx_reg;
        hdr_next   = hdr_reg;
        found_next = found_reg;
        pz_next    = pz_reg;
        off_next   = off_reg;
        dnum_next  = dnum_reg;
        ndesc_next = ndesc_reg;
        wl_next    = wl_reg;
        wh_next    = wh_reg;
        hl_next    = hl_reg;
        hh_next    = hh_reg;
        wr_en      = 1'b0;
        off_rel    = off_reg - 5'(edid_bbp_pkg::NameOff);
        wr_idx     = off_rel[3:0];
        in_desc    = (idx_reg >= 8'(edid_bbp_pkg::DescFirst)) &&
                     (idx_reg < 8'(edid_bbp_pkg::DescEnd));

        if (take && (idx_reg < 8'(edid_bbp_pkg::BlockLen)))
        begin
            idx_next = idx_reg + 8'd1;
            if ((idx_reg == 8'd0) && (beat_byte != edid_bbp_pkg::HdrZero))
                hdr_next = 1'b0;
            if (((idx_reg == 8'd1) || (idx_reg == 8'd2)) &&
                (beat_byte != edid_bbp_pkg::HdrFf))
                hdr_next = 1'b0;
            if (idx_reg == 8'd56)
                wl_next = beat_byte;
            if (idx_reg == 8'd58)
                wh_next = beat_byte[7:4];
            if (idx_reg == 8'd59)
                hl_next = beat_byte;
            if (idx_reg == 8'd61)
                hh_next = beat_byte[7:4];

            if (in_desc)
            begin
                if (off_reg == 5'd0)
                    pz_next = {1'b0, beat_byte == 8'd0};
                else if (off_reg == 5'd1)
                begin
                    if (beat_byte == 8'd0)
                        pz_next[1] = 1'b1;
                end
                else if (off_reg == 5'd3)
                begin
                    if (!found_reg && (pz_reg == 2'b11) &&
                        (beat_byte == edid_bbp_pkg::NameTag))
                    begin
                        found_next = 1'b1;
                        ndesc_next = dnum_reg;
                    end
                end
                else if ((off_reg >= 5'(edid_bbp_pkg::NameOff)) && found_reg &&
                         (ndesc_reg == dnum_reg))
                    wr_en = 1'b1;

                // offset within the current 18-byte descriptor
                if (off_reg == 5'(edid_bbp_pkg::DescLen - 1))
                begin
                    off_next  = 5'd0;
                    dnum_next = dnum_reg + 2'd1;
                end
                else
                    off_next = off_reg + 5'd1;
            end
        end

        store_next = store_reg;
        if (wr_en)
            store_next[wr_idx] = beat_byte;

        blk_ok      = (idx_next == 8'(edid_bbp_pkg::BlockLen)) && hdr_next;
        snap.blk_ok = blk_ok;
        snap.found  = blk_ok && found_next;
        snap.name   = store_next;
        if (blk_ok && (wl_next != 8'd0) && (hl_next != 8'd0))
        begin
            snap.width  = {wh_next, wl_next};
            snap.height = {hh_next, hl_next};
        end
        else
        begin
            snap.width  = 12'd0;
            snap.height = 12'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 8'd0;
            hdr_reg   <= 1'b1;
            found_reg <= 1'b0;
            pz_reg    <= 2'b00;
            off_reg   <= 5'd0;
            dnum_reg  <= 2'd0;
            ndesc_reg <= 2'd0;
            wl_reg    <= 8'd0;
            wh_reg    <= 4'd0;
            hl_reg    <= 8'd0;
            hh_reg    <= 4'd0;
        end
        else if (take && beat_last)
        begin
            // block done, start over for the next one
            idx_reg   <= 8'd0;
            hdr_reg   <= 1'b1;
            found_reg <= 1'b0;
            pz_reg    <= 2'b00;
            off_reg   <= 5'd0;
            dnum_reg  <= 2'd0;
            ndesc_reg <= 2'd0;
            wl_reg    <= 8'd0;
            wh_reg    <= 4'd0;
            hl_reg    <= 8'd0;
            hh_reg    <= 4'd0;
        end
        else
        begin
            idx_reg   <= idx_next;
            hdr_reg   <= hdr_next;
            found_reg <= found_next;
            pz_reg    <= pz_next;
            off_reg   <= off_next;
            dnum_reg  <= dnum_next;
            ndesc_reg <= ndesc_next;
            wl_reg    <= wl_next;
            wh_reg    <= wh_next;
            hl_reg    <= hl_next;
            hh_reg    <= hh_next;
        end
    end

    // name bytes are only read once all of them were written
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_reg[wr_idx] <= beat_byte;
    end

endmodule

/* src/edid_bbp_shaper.sv */
// ----------------------------------------------------------------------------
// edid_bbp_shaper
// Cuts and trims the monitor name and holds the result register.
// ----------------------------------------------------------------------------
module edid_bbp_shaper
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  edid_bbp_pkg::snap_t snap,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output edid_bbp_pkg::result_t result
);

    logic                  out_valid_reg;
    edid_bbp_pkg::result_t res_reg, res_next;

    logic [edid_bbp_pkg::NameLen-1:0]      keep;
    logic [edid_bbp_pkg::NameLen-1:0]      solid;
    logic                                  seen_term;
    logic                                  seen_start;
    logic [3:0]                            start;
    logic [3:0]                            stop;
    logic [3:0]                            len;
    logic [edid_bbp_pkg::NameLen-1:0][7:0] shifted;
    logic [4:0]                            src;

    always_comb
    begin
        // bytes ahead of the first terminator, and the non-blank ones among them
        seen_term = 1'b0;
        for (int i = 0; i < edid_bbp_pkg::NameLen; i++)
        begin
            if (edid_bbp_pkg::is_term(snap.name[i]))
                seen_term = 1'b1;
            keep[i]  = !seen_term;
            solid[i] = keep[i] && !edid_bbp_pkg::is_space(snap.name[i]);
        end

        seen_start = 1'b0;
        start      = 4'd0;
        stop       = 4'd0;
        for (int i = 0; i < edid_bbp_pkg::NameLen; i++)
        begin
            if (solid[i] && !seen_start)
            begin
                start      = 4'(i);
                seen_start = 1'b1;
            end
            if (solid[i])
                stop = 4'(i + 1);
        end
        len = seen_start ? (stop - start) : 4'd0;

        for (int j = 0; j < edid_bbp_pkg::NameLen; j++)
        begin
            src = 5'(j) + {1'b0, start};
            if ((4'(j) < len) && (src < 5'(edid_bbp_pkg::NameLen)))
                shifted[j] = snap.name[src[3:0]];
            else
                shifted[j] = 8'd0;
        end

        res_next.valid_res  = snap.blk_ok;
        res_next.px_width   = snap.width;
        res_next.px_height  = snap.height;
        res_next.name_found = snap.found;
        if (snap.found)
        begin
            res_next.name_length     = len;
            res_next.name_chars_low  = shifted[7:0];
            res_next.name_chars_high = shifted[edid_bbp_pkg::NameLen-1:8];
        end
        else
        begin
            res_next.name_length     = edid_bbp_pkg::UnknownLen;
            res_next.name_chars_low  = edid_bbp_pkg::UnknownChars;
            res_next.name_chars_high = 40'd0;
        end
    end

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= res_next;
    end

endmodule

/* src/edid_base_block_parser_core.sv */
// ----------------------------------------------------------------------------
// edid_base_block_parser_core
// EDID base block parser: header check, monitor name and native size.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the EDID bytes from offset 0 upward, one byte per beat, with
//   s_axis_tlast on the final byte of the data. m_axis returns one result beat
//   per block, built from the bytes up to and including the tlast beat.
//   Bytes past the 128th are dropped but their tlast still closes the block;
//   a short block or a bad header gives an invalid, zero-sized "Unknown".
// Timing:
//   one byte accepted every cycle while no tlast beat is held (see below). The
//   result beat passes the input register, the block summary register, then
//   the result register behind the name trim logic.
//   The next block's bytes may follow the tlast beat directly.
// Reset and stalls:
//   rst_n clears all control state; no clearing pass is needed. While the
//   result waits on m_axis_tready, data bytes keep flowing; a tlast beat is
//   held only when both the summary and the result registers are occupied.
// ----------------------------------------------------------------------------
module edid_base_block_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] edid_byte
    input  logic         s_axis_tlast,  // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] valid_res, [12:1] px_width, [24:13] px_height, [25] name_found,
    // [29:26] name_length, [93:30] name_chars_low, [133:94] name_chars_high,
    // [135:134] zero
    output logic [edid_bbp_pkg::OutDataW-1:0] m_axis_tdata
);

    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;
    logic       a_consume;

    logic                  snap_valid_reg;
    edid_bbp_pkg::snap_t   snap_reg;
    edid_bbp_pkg::snap_t   snap_comb;
    logic                  snap_ready;
    logic                  shp_ready;
    edid_bbp_pkg::result_t result;

    assign snap_ready    = !snap_valid_reg || shp_ready;
    assign a_consume     = a_valid_reg && (!a_last_reg || snap_ready);
    assign s_axis_tready = !a_valid_reg || a_consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (s_axis_tready)
            a_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            a_byte_reg <= s_axis_tdata;
            a_last_reg <= s_axis_tlast;
        end
    end

    edid_bbp_capture u_capture
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (a_consume),
        .beat_byte (a_byte_reg),
        .beat_last (a_last_reg),
        .snap      (snap_comb)
    );

    // block summary, loaded on the tlast beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (snap_ready)
            snap_valid_reg <= a_consume && a_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_consume && a_last_reg)
            snap_reg <= snap_comb;
    end

    edid_bbp_shaper u_shaper
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (snap_valid_reg),
        .snap      (snap_reg),
        .in_ready  (shp_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {2'b00, result};

endmodule

/* src/edid_bbp_checker.sv */
// ----------------------------------------------------------------------------
// edid_bbp_checker
// Port-level checks of the EDID base block parser, bound to the top level.
// ----------------------------------------------------------------------------
module edid_bbp_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // invalid block: zero size, no name, "Unknown"
    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |->
            (m_axis_tdata[24:1] == 24'd0) && !m_axis_tdata[25] &&
            (m_axis_tdata[29:26] == edid_bbp_pkg::UnknownLen) &&
            (m_axis_tdata[93:30] == edid_bbp_pkg::UnknownChars))
        else $error("invalid result not reduced to Unknown");

    // a found name comes from a valid block, fits in 13 characters, and the pad bits are zero
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[25] |->
            m_axis_tdata[0] && (m_axis_tdata[29:26] <= 4'd13) &&
            (m_axis_tdata[135:134] == 2'b00))
        else $error("found name with bad length or invalid block");

    // no result beat straight out of reset
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result beat during reset");

endmodule

bind edid_base_block_parser_core edid_bbp_checker u_edid_bbp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
